[hdl/fbbs_pkg.sv]
// Shared constants, types and control records of the Fibonacci biased bit sampler.
`timescale 1ns / 1ps

package fbbs_pkg;

   localparam int DEFAULT_RANDOM_WIDTH = 32;
   localparam int FIB_WIDTH            = 32;
   localparam int PROD_WIDTH           = 2 * FIB_WIDTH;
   localparam int LIMIT_WIDTH          = 5;
   localparam int COUNT_WIDTH          = 5;
   localparam int RSP_DATA_WIDTH       = 8;

   localparam logic [LIMIT_WIDTH-1:0] MIN_ROUNDS  = LIMIT_WIDTH'(1);
   localparam logic [LIMIT_WIDTH-1:0] MAX_ROUNDS  = LIMIT_WIDTH'(20);
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = MAX_ROUNDS;

   localparam logic [FIB_WIDTH-1:0] FIB_START = FIB_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_MOD,
      ST_MUL_BOUND,
      ST_DIVIDE,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_mod;
      logic calc_bound;
      logic div_step;
      logic to_second;
      logic advance;
      logic restart;
      logic emit;
      logic emit_choice;
      logic emit_limit;
   } cmd_type;

   typedef struct packed {
      logic phase;
      logic less_than;
      logic final_round;
      logic div_last;
   } status_type;

endpackage

[hdl/fbbs_ctrl.sv]
// Controller state machine that sequences each transaction and the result handshake.
`timescale 1ns / 1ps

module fbbs_ctrl
   import fbbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_MOD;
            end
         end
         ST_MUL_MOD: begin
            cmd.calc_mod = 1'b1;
            state_in     = ST_MUL_BOUND;
         end
         ST_MUL_BOUND: begin
            cmd.calc_bound = 1'b1;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.phase) begin
               if (status.less_than) begin
                  if (slot_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_choice = 1'b1;
                     cmd.restart     = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end else begin
                  cmd.to_second = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               if (status.less_than || status.final_round) begin
                  if (slot_free) begin
                     cmd.emit       = 1'b1;
                     cmd.emit_limit = !status.less_than;
                     cmd.restart    = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A new result must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while occupied");

   // A result appears only as the outcome of a decision.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("result raised outside the decision step");

   // An accepted transaction always starts the multiplier sequence.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_MUL_MOD)
      else $error("accepted transaction did not start the sequence");

   // The remainder loop hands over to the decision after its last step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_last) |=> state_ff == ST_DECIDE)
      else $error("remainder loop did not end in the decision step");

endmodule

[hdl/fbbs_datapath.sv]
// Datapath: Fibonacci pair, multiplier, bit-serial remainder unit and result register.
`timescale 1ns / 1ps

module fbbs_datapath
   import fbbs_pkg::*;
#(
   parameter int RANDOM_WIDTH = DEFAULT_RANDOM_WIDTH
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [RANDOM_WIDTH-1:0] word,
   input  logic                    csr_wen,
   input  logic [LIMIT_WIDTH-1:0]  csr_wdata,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic                    rsp_choice,
   output logic                    rsp_limit
);

   localparam int BIT_CNT_WIDTH = $clog2(RANDOM_WIDTH);

   logic [LIMIT_WIDTH-1:0]   limit_ff, limit_in;
   logic                     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [FIB_WIDTH-1:0]     fib_lower_ff, fib_lower_in;
   logic [FIB_WIDTH-1:0]     fib_upper_ff, fib_upper_in;
   logic [RANDOM_WIDTH-1:0]  word_ff, word_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [PROD_WIDTH-1:0]    modulus_ff, modulus_in;
   logic [PROD_WIDTH-1:0]    bound_ff, bound_in;
   logic [PROD_WIDTH-1:0]    rem_ff, rem_in;
   logic                     choice_ff, choice_in;
   logic                     limit_hit_ff, limit_hit_in;

   logic [FIB_WIDTH-1:0]     fib_third;
   logic [FIB_WIDTH-1:0]     fib_fourth;
   logic [FIB_WIDTH-1:0]     mul_b;
   logic [PROD_WIDTH-1:0]    product;
   logic [PROD_WIDTH:0]      rem_shift;
   logic [PROD_WIDTH:0]      rem_diff;
   logic [LIMIT_WIDTH-1:0]   eff_limit;
   logic [COUNT_WIDTH:0]     count_next;

   assign fib_third  = fib_lower_ff + fib_upper_ff;
   assign fib_fourth = fib_upper_ff + fib_third;
   assign mul_b      = cmd.calc_mod ? fib_fourth : fib_third;
   assign product    = PROD_WIDTH'(fib_lower_ff) * PROD_WIDTH'(mul_b);

   assign rem_shift = {rem_ff, word_ff[RANDOM_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, modulus_ff};

   always_comb begin
      priority if (limit_ff < MIN_ROUNDS) begin
         eff_limit = MIN_ROUNDS;
      end else if (limit_ff > MAX_ROUNDS) begin
         eff_limit = MAX_ROUNDS;
      end else begin
         eff_limit = limit_ff;
      end
   end

   assign count_next = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(1);

   assign status.phase       = phase_ff;
   assign status.less_than   = rem_ff < bound_ff;
   assign status.final_round = count_next >= (COUNT_WIDTH + 1)'(eff_limit);
   assign status.div_last    = bit_cnt_ff == '0;

   assign rsp_choice = choice_ff;
   assign rsp_limit  = limit_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         fib_lower_ff <= FIB_START;
         fib_upper_ff <= FIB_START;
      end else begin
         limit_ff     <= limit_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         fib_lower_ff <= fib_lower_in;
         fib_upper_ff <= fib_upper_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bit_cnt_ff   <= bit_cnt_in;
      modulus_ff   <= modulus_in;
      bound_ff     <= bound_in;
      rem_ff       <= rem_in;
      choice_ff    <= choice_in;
      limit_hit_ff <= limit_hit_in;
   end

   always_comb begin
      limit_in     = csr_wen ? csr_wdata : limit_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      fib_lower_in = fib_lower_ff;
      fib_upper_in = fib_upper_ff;
      priority if (cmd.restart) begin
         phase_in     = 1'b0;
         count_in     = '0;
         fib_lower_in = FIB_START;
         fib_upper_in = FIB_START;
      end else if (cmd.advance) begin
         phase_in     = 1'b0;
         count_in     = count_next[COUNT_WIDTH-1:0];
         fib_lower_in = fib_third;
         fib_upper_in = fib_fourth;
      end else if (cmd.to_second) begin
         phase_in = 1'b1;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_comb begin
      word_in      = word_ff;
      bit_cnt_in   = bit_cnt_ff;
      modulus_in   = modulus_ff;
      bound_in     = bound_ff;
      rem_in       = rem_ff;
      choice_in    = choice_ff;
      limit_hit_in = limit_hit_ff;
      if (cmd.load) begin
         word_in    = word;
         bit_cnt_in = BIT_CNT_WIDTH'(RANDOM_WIDTH - 1);
         rem_in     = '0;
      end
      if (cmd.calc_mod) begin
         modulus_in = phase_ff ? product : PROD_WIDTH'(fib_third);
      end
      if (cmd.calc_bound) begin
         bound_in = phase_ff ? product : PROD_WIDTH'(fib_upper_ff);
      end
      if (cmd.div_step) begin
         word_in    = {word_ff[RANDOM_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BIT_CNT_WIDTH'(1);
         if (!rem_diff[PROD_WIDTH]) begin
            rem_in = rem_diff[PROD_WIDTH-1:0];
         end else begin
            rem_in = rem_shift[PROD_WIDTH-1:0];
         end
      end
      if (cmd.emit) begin
         choice_in    = cmd.emit_choice;
         limit_hit_in = cmd.emit_limit;
      end
   end

endmodule

[hdl/fibonacci_biased_bit_sampler_core.sv]
// Top level of the Fibonacci biased bit sampler: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Each input transaction carries one uniform random word. From acceptance it passes through
// the multiplier states ST_MUL_MOD and ST_MUL_BOUND, the bit-serial remainder unit, which
// takes one remainder bit per cycle, and the decision step before the block is ready for the
// next word. A transaction either completes a result, which is held in an output register
// until the consumer takes it, or advances the sampler to its next draw without a result. A
// decision that produces a result waits while an earlier result is still untaken. The round
// limit may be written only while the block is idle.

module fibonacci_biased_bit_sampler_core
   import fbbs_pkg::*;
#(
   parameter int RANDOM_WIDTH = DEFAULT_RANDOM_WIDTH
)
(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: random_word.
   input  logic [((RANDOM_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // Fields from bit 0: choice_bit, limit_hit, zero fill.
   output logic [RSP_DATA_WIDTH-1:0]               rsp_tdata,
   input  logic                                    csr_wen,
   input  logic [LIMIT_WIDTH-1:0]                  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_choice;
   logic       rsp_limit;

   assign rsp_tdata = {(RSP_DATA_WIDTH - 2)'(0), rsp_limit, rsp_choice};

   fbbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fbbs_datapath #(
      .RANDOM_WIDTH (RANDOM_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .word       (req_tdata[RANDOM_WIDTH-1:0]),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_choice (rsp_choice),
      .rsp_limit  (rsp_limit)
   );

endmodule
